### src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Sizes, operation and status codes, controller states and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Ring size and derived widths
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W   = COUNT_W + 1;
  localparam int DATA_W  = 32;
  localparam int OCC_W   = 5;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // request accepted this cycle
    logic rd_done;   // slot read data is valid, finish the pop result
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dq_stat_t;

endpackage

### src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl: handshake and sequencing controller
// Accepts requests, issues start and read-done commands and owns out_valid.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       opcode,
  output logic             out_valid,
  input  logic             out_ready,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_cmd_t  cmd
);

  dq_pkg::state_t state, state_next;
  logic           out_valid_next;
  logic           is_pop;
  logic           need_read;

  assign is_pop = (opcode == dq_pkg::OP_POP_FRONT) || (opcode == dq_pkg::OP_POP_REAR);

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    need_read      = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      dq_pkg::S_IDLE: begin
        in_ready  = !out_valid || out_ready;
        cmd.start = in_valid && in_ready;
        need_read = cmd.start && is_pop && !stat.empty;
        if (need_read) begin
          state_next = dq_pkg::S_READ;
        end else if (cmd.start) begin
          out_valid_next = 1'b1;
        end
      end
      dq_pkg::S_READ: begin
        // result register was freed when this request was accepted
        cmd.rd_done    = 1'b1;
        out_valid_next = 1'b1;
        state_next     = dq_pkg::S_IDLE;
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath: ring pointers, slot RAM, cached front value and result
// Head index and count track the ring; the front slot is mirrored in a
// register so each operation needs at most one RAM read.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dq_pkg::dq_cmd_t                   cmd,
  output dq_pkg::dq_stat_t                  stat,
  input  logic [1:0]                        opcode,
  input  logic signed [dq_pkg::DATA_W-1:0]  value_in,
  output logic signed [dq_pkg::DATA_W-1:0]  value_out,
  output logic [1:0]                        status,
  output logic signed [dq_pkg::DATA_W-1:0]  front_value,
  output logic [dq_pkg::OCC_W-1:0]          occupancy
);

  localparam logic [dq_pkg::SUM_W-1:0]   DepthSum  = dq_pkg::SUM_W'(dq_pkg::DEPTH);
  localparam logic [dq_pkg::COUNT_W-1:0] DepthCnt  = dq_pkg::COUNT_W'(dq_pkg::DEPTH);
  localparam logic [dq_pkg::ADDR_W-1:0]  LastAddr  = dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1);
  localparam logic [dq_pkg::DATA_W-1:0]  EmptyMark = '1;

  // Reduce a sum below twice the depth into a slot index
  function automatic logic [dq_pkg::ADDR_W-1:0] wrap(input logic [dq_pkg::SUM_W-1:0] s);
    logic [dq_pkg::SUM_W-1:0] r;
    r = (s >= DepthSum) ? (s - DepthSum) : s;
    return r[dq_pkg::ADDR_W-1:0];
  endfunction

  logic [dq_pkg::ADDR_W-1:0]  head, head_next;
  logic [dq_pkg::COUNT_W-1:0] count, count_next;
  logic [dq_pkg::DATA_W-1:0]  front_reg, front_reg_next;
  logic                       pend_front;

  logic [dq_pkg::SUM_W-1:0]   head_ext, tail_sum;
  logic [dq_pkg::ADDR_W-1:0]  head_dec;
  logic                       we;
  logic [dq_pkg::ADDR_W-1:0]  waddr, raddr;
  logic [dq_pkg::DATA_W-1:0]  rdata;
  logic [dq_pkg::DATA_W-1:0]  vo_next;
  dq_pkg::status_t            st_next;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == DepthCnt);

  assign head_ext = dq_pkg::SUM_W'(head);
  assign tail_sum = head_ext + dq_pkg::SUM_W'(count);
  assign head_dec = (head == '0) ? LastAddr : (head - 1'b1);

  // Read address: slot after the head, or the rear slot
  assign raddr = (opcode == dq_pkg::OP_POP_FRONT) ? wrap(head_ext + 1'b1)
                                                  : wrap(tail_sum - 1'b1);

  // Next ring state and immediate result fields
  always_comb begin
    head_next      = head;
    count_next     = count;
    front_reg_next = front_reg;
    we             = 1'b0;
    waddr          = wrap(tail_sum);
    vo_next        = '0;
    st_next        = dq_pkg::ST_OK;
    unique case (opcode)
      dq_pkg::OP_PUSH_REAR: begin
        if (stat.full) begin
          st_next = dq_pkg::ST_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + 1'b1;
          if (stat.empty) begin
            front_reg_next = value_in;
          end
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (stat.full) begin
          st_next = dq_pkg::ST_FULL;
        end else begin
          we             = 1'b1;
          waddr          = head_dec;
          head_next      = head_dec;
          count_next     = count + 1'b1;
          front_reg_next = value_in;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (stat.empty) begin
          st_next = dq_pkg::ST_EMPTY;
        end else begin
          vo_next    = front_reg;
          head_next  = wrap(head_ext + 1'b1);
          count_next = count - 1'b1;
        end
      end
      dq_pkg::OP_POP_REAR: begin
        if (stat.empty) begin
          st_next = dq_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        st_next = dq_pkg::ST_OK;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.start) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Front cache and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      front_reg   <= front_reg_next;
      pend_front  <= (opcode == dq_pkg::OP_POP_FRONT);
      value_out   <= vo_next;
      status      <= st_next;
      occupancy   <= dq_pkg::OCC_W'(count_next);
      front_value <= (count_next == '0) ? EmptyMark : front_reg_next;
    end else if (cmd.rd_done) begin
      if (pend_front) begin
        front_reg   <= rdata;
        front_value <= (count == '0) ? EmptyMark : rdata;
      end else begin
        value_out   <= rdata;
        front_value <= (count == '0) ? EmptyMark : front_reg;
      end
    end
  end

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.start && we),
    .waddr (waddr),
    .wdata (value_in),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

### src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Ring buffer with push and pop at both ends, one result per request.
// ----------------------------------------------------------------------------
// Each request is one operation (push rear, push front, pop front, pop rear)
// and yields exactly one result with the popped value, a status, the value
// now at the front (-1 when empty) and the occupancy. Pushes and pops on an
// empty queue finish without a RAM read; a successful pop also passes through
// the read state for the registered read of the slot RAM (the popped rear value, or the new
// front after a front pop). A new request is taken while the previous result
// is being delivered. No clearing pass runs after reset; a slot that was
// never written never reaches an output.
module double_ended_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic signed [dq_pkg::DATA_W-1:0] value_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dq_pkg::DATA_W-1:0] value_out,
  output logic [1:0]                       status,
  output logic signed [dq_pkg::DATA_W-1:0] front_value,
  output logic [dq_pkg::OCC_W-1:0]         occupancy
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .value_in    (value_in),
    .value_out   (value_out),
    .status      (status),
    .front_value (front_value),
    .occupancy   (occupancy)
  );

endmodule
